// File: design/gsp_pkg.sv
// Shared definitions for the generational slot pool.
// Holds pool sizing constants, the operation codes and the transfer structs.
// No dependencies.
package gsp_pkg;

   // Pool sizing
   localparam int SLOTS    = 16;
   localparam int GEN_BITS = 8;
   localparam int IDX_BITS = $clog2(SLOTS);      // slot index width
   localparam int PTR_BITS = $clog2(SLOTS + 1);  // free-list pointer, SLOTS ends the list
   localparam int CNT_BITS = $clog2(SLOTS + 1);  // population counters

   localparam logic [GEN_BITS-1:0] GEN_MAX   = {GEN_BITS{1'b1}};
   localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);
   localparam logic [PTR_BITS-1:0] LIST_END  = PTR_BITS'(SLOTS);

   // Operation codes; code 3 is unused and does nothing
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_LOOKUP  = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [4:0]          handle_index;
      logic [7:0]          handle_generation;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [3:0]          slot_index;
      logic [7:0]          slot_generation;
      logic [4:0]          available_count;
      logic [4:0]          live_count;
      logic [4:0]          retired_count;
   } rsp_type;

endpackage

// File: design/gsp_core.sv
// Slot pool state and per-operation logic: free list, generations, live marks
// and counters. Result is combinational from the current state; state updates on commit.
// Depends on gsp_pkg.
module gsp_core
   import gsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    commit,
   input  req_type item,
   output rsp_type result
);

   // Pool state
   logic [PTR_BITS-1:0] next_free_ff [SLOTS];
   logic [GEN_BITS-1:0] slot_gen_ff  [SLOTS];
   logic [SLOTS-1:0]    slot_live_ff;
   logic [PTR_BITS-1:0] free_head_ff, free_head_in;
   logic [CNT_BITS-1:0] free_total_ff, free_total_in;
   logic [CNT_BITS-1:0] live_total_ff, live_total_in;
   logic [CNT_BITS-1:0] retired_total_ff, retired_total_in;

   logic [IDX_BITS-1:0] head_slot, hnd_slot, rd_slot;
   logic                head_avail, hnd_in_range, hnd_match;
   logic [GEN_BITS-1:0] rd_gen;
   logic                do_alloc, do_release, do_recycle;

   // Table reads: allocate looks at the list head, the others at the handle
   assign head_slot    = free_head_ff[IDX_BITS-1:0];
   assign hnd_slot     = item.handle_index[IDX_BITS-1:0];
   assign head_avail   = free_head_ff < LIST_END;
   assign hnd_in_range = item.handle_index < 5'(SLOTS);
   assign rd_slot      = (item.operation == OP_ALLOC) ? head_slot : hnd_slot;
   assign rd_gen       = slot_gen_ff[rd_slot];
   assign hnd_match    = hnd_in_range && slot_live_ff[hnd_slot]
                         && (slot_gen_ff[hnd_slot] == item.handle_generation);

   // Operation decode and next counter values
   always_comb begin
      do_alloc         = 1'b0;
      do_release       = 1'b0;
      result           = '0;
      free_head_in     = free_head_ff;
      free_total_in    = free_total_ff;
      live_total_in    = live_total_ff;
      retired_total_in = retired_total_ff;
      case (item.operation)
         OP_ALLOC: begin
            if (head_avail) begin
               do_alloc               = 1'b1;
               result.ok              = 1'b1;
               result.slot_index      = 4'(head_slot);
               result.slot_generation = 8'(rd_gen);
            end
         end
         OP_LOOKUP: begin
            if (hnd_match) begin
               result.ok              = 1'b1;
               result.slot_index      = 4'(hnd_slot);
               result.slot_generation = 8'(rd_gen);
            end
         end
         OP_RELEASE: begin
            if (hnd_match) begin
               do_release             = 1'b1;
               result.ok              = 1'b1;
               result.slot_index      = 4'(hnd_slot);
               result.slot_generation = 8'(rd_gen);
            end
         end
         default: begin
         end
      endcase

      do_recycle = do_release && (rd_gen != GEN_MAX);

      if (do_alloc) begin
         free_head_in  = next_free_ff[head_slot];
         free_total_in = free_total_ff - CNT_BITS'(1);
         live_total_in = live_total_ff + CNT_BITS'(1);
      end
      if (do_release) begin
         live_total_in = live_total_ff - CNT_BITS'(1);
         if (do_recycle) begin
            free_head_in  = PTR_BITS'(hnd_slot);
            free_total_in = free_total_ff + CNT_BITS'(1);
         end else begin
            retired_total_in = retired_total_ff + CNT_BITS'(1);
         end
      end

      result.available_count = 5'(free_total_in);
      result.live_count      = 5'(live_total_in);
      result.retired_count   = 5'(retired_total_in);
   end

   // State update on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            next_free_ff[i] <= PTR_BITS'(i + 1);
            slot_gen_ff[i]  <= GEN_FIRST;
         end
         slot_live_ff     <= '0;
         free_head_ff     <= '0;
         free_total_ff    <= CNT_BITS'(SLOTS);
         live_total_ff    <= '0;
         retired_total_ff <= '0;
      end else if (commit) begin
         free_head_ff     <= free_head_in;
         free_total_ff    <= free_total_in;
         live_total_ff    <= live_total_in;
         retired_total_ff <= retired_total_in;
         if (do_alloc) begin
            slot_live_ff[head_slot] <= 1'b1;
         end
         if (do_release) begin
            slot_live_ff[hnd_slot] <= 1'b0;
         end
         if (do_recycle) begin
            slot_gen_ff[hnd_slot]  <= rd_gen + GEN_BITS'(1);
            next_free_ff[hnd_slot] <= free_head_ff;
         end
      end
   end

   // Every slot is free, live or retired
   a_population: assert property (@(posedge clock) disable iff (reset)
      ((CNT_BITS+2)'(free_total_ff) + (CNT_BITS+2)'(live_total_ff)
       + (CNT_BITS+2)'(retired_total_ff)) == (CNT_BITS+2)'(SLOTS))
      else $error("slot population does not add up");

   // The list is empty exactly when the free count is zero
   a_head_end: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == LIST_END) == (free_total_ff == '0))
      else $error("free-list head disagrees with free count");

   // A committed allocation marks its slot live
   a_alloc_live: assert property (@(posedge clock) disable iff (reset)
      commit && do_alloc |=> slot_live_ff[$past(head_slot)])
      else $error("allocated slot not marked live");

   // The live count matches the live marks
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_live_ff) == int'(live_total_ff))
      else $error("live count disagrees with live marks");

endmodule

// File: design/generational_slot_pool.sv
// Generational slot pool top level: request register, pool core, result register.
// Depends on gsp_pkg and gsp_core.
//
// Usage:
//   Request channel req_valid/req_stall/req_data carries one operation per
//   transfer: allocate, lookup handle or release handle. Result channel
//   rsp_valid/rsp_stall/rsp_data returns exactly one result per request,
//   in order, with the available, live and retired counts after that request.
//   A request taken into the request register has its result computed by the
//   core and loaded into the result register once that register is free;
//   then rsp_valid rises. The block takes one request per cycle while the
//   receiver does not stall; each operation is at most one free-list pop or
//   push and one table read between the two registers.
//   When the receiver stalls, the result register holds and a waiting request
//   stays in the request register; req_stall rises only once both are full.
//   Reset (synchronous, active high) empties both registers, puts every slot on the free
//   list in index order with generation 1, and clears the live and retired counts.
module generational_slot_pool
   import gsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    req_valid_ff;
   req_type req_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    advance;

   // Move the held request into the result register when it is empty or its result is being taken
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   gsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (req_item_ff),
      .result (rsp_data_in)
   );

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_item_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
